// File: sv/assert_macros.svh
// Assertion helper macros for the hole-punch retry scheduler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/hprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hprs_pkg
// Shared types and constants of the hole-punch retry scheduler.
// ----------------------------------------------------------------------------
package hprs_pkg;

	localparam int MAX_RESULTS = 16;

	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_ADD     = 2'd1;
	localparam logic [1:0] MODE_SUCCESS = 2'd2;
	localparam logic [1:0] MODE_PACKET  = 2'd3;

	localparam logic [1:0] KIND_PUNCH   = 2'd0;
	localparam logic [1:0] KIND_PEER    = 2'd1;
	localparam logic [1:0] KIND_SERVER  = 2'd2;
	localparam logic [1:0] KIND_REJECT  = 2'd3;

	localparam logic [1:0] REG_INTERVAL = 2'd0;
	localparam logic [1:0] REG_BUDGET   = 2'd1;
	localparam logic [1:0] REG_SRV_IP   = 2'd2;
	localparam logic [1:0] REG_SRV_PORT = 2'd3;

	localparam logic [15:0] RESET_INTERVAL = 16'd30;
	localparam logic [7:0]  RESET_BUDGET   = 8'd100;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] now;
		logic [63:0] node_id;
		logic [31:0] first_ip;
		logic [15:0] first_port;
		logic [31:0] second_ip;
		logic [15:0] second_port;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] peer_node;
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COUNT,
		ST_TICK,
		ST_PUNCH2,
		ST_COMPACT,
		ST_ADD,
		ST_PEERSCAN,
		ST_MARK,
		ST_PKT,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [31:0] server_ip;
		logic [15:0] server_port;
		logic [15:0] interval;
		logic [7:0]  budget;
	} cfg_t;

endpackage

// File: sv/hprs_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hprs_regs
// Configuration register file with plain write port.
// ----------------------------------------------------------------------------
module hprs_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output hprs_pkg::cfg_t     cfg
);
	import hprs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval    <= RESET_INTERVAL;
			cfg_q.budget      <= RESET_BUDGET;
			cfg_q.server_ip   <= '0;
			cfg_q.server_port <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL: cfg_q.interval    <= cfg_data[15:0];
				REG_BUDGET:   cfg_q.budget      <= cfg_data[7:0];
				REG_SRV_IP:   cfg_q.server_ip   <= cfg_data;
				REG_SRV_PORT: cfg_q.server_port <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/hole_punch_retry_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hole_punch_retry_scheduler_top
// Peer target table with retry scheduling, success set and packet lookup.
// ----------------------------------------------------------------------------
// Usage: one input transaction (in_valid/in_ready, struct in_item) gives zero
// or more result transactions (out_valid/out_ready, struct out_item); the last
// result of an input carries last. Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// A sequencer walks the target slots one per cycle, but for punch rounds
// and output stalls, through one shared compare/add unit. A tick counts the
// due targets to place last, issues two results per due target, compacts
// and flushes; an add stores or rejects a target; an unknown success records
// its peer and marks its targets; a packet not from the server scans the slots.
// in_ready is high only in the idle state. Results leave through a single
// output register; while the receiver stalls the sequencer holds.
// Reset clears the slot valid bits, the peer count and loads the register
// defaults (interval 30, budget 100); the slot and peer stores are not cleared.
// ----------------------------------------------------------------------------
module hole_punch_retry_scheduler_top #(
	parameter int TARGETS = 8,
	parameter int PEERS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hprs_pkg::in_item_t    in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output hprs_pkg::out_item_t   out_item,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);
	import hprs_pkg::*;
	`include "assert_macros.svh"

	localparam int TW = (TARGETS > 1) ? $clog2(TARGETS) : 1;
	localparam int PW = (PEERS > 1) ? $clog2(PEERS) : 1;
	localparam int CW = $clog2(PEERS + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);
	localparam int IW = (TW + 1 > CW) ? TW + 1 : CW;

	cfg_t cfg;

	hprs_regs u_regs (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cfg(cfg)
	);

	logic [TARGETS-1:0] valid_q;
	logic [63:0] node_q [TARGETS];
	logic [31:0] pip_q [TARGETS];
	logic [15:0] ppt_q [TARGETS];
	logic [31:0] qip_q [TARGETS];
	logic [15:0] qpt_q [TARGETS];
	logic [7:0]  left_q [TARGETS];
	logic [31:0] due_q [TARGETS];
	logic [TARGETS-1:0] succ_q;
	logic [63:0] peer_q [PEERS];
	logic [CW-1:0] pcnt_q;

	state_t state_q, state_d;
	in_item_t item_q;
	logic [IW-1:0] idx_q;
	logic [TW:0] wr_q;
	logic [NW-1:0] nres_q;
	logic [NW-1:0] etot_q;
	logic ovalid_q;
	out_item_t obuf_q;
	logic known_q;

	logic [TW-1:0] ix, wx;
	assign ix = idx_q[TW-1:0];
	assign wx = wr_q[TW-1:0];
	logic idx_end;
	assign idx_end = (idx_q == IW'(TARGETS));

	// shared compare unit
	logic [31:0] diff;
	logic due_ok, live_ok, room_ok, cnt_room, ep_hit, keep, punch_last;
	assign diff    = item_q.now - due_q[ix];
	assign due_ok  = !diff[31];
	assign live_ok = valid_q[ix] && (left_q[ix] != 8'd0) && !succ_q[ix];
	assign room_ok = (nres_q + NW'(2)) <= NW'(MAX_RESULTS);
	assign cnt_room = (etot_q + NW'(2)) <= NW'(MAX_RESULTS);
	assign punch_last = ((nres_q + NW'(1)) == etot_q);
	assign ep_hit  = valid_q[ix] &&
		((pip_q[ix] == item_q.first_ip && ppt_q[ix] == item_q.first_port) ||
		 (qip_q[ix] == item_q.first_ip && qpt_q[ix] == item_q.first_port));
	assign keep    = valid_q[ix] && (left_q[ix] != 8'd0) && !succ_q[ix];

	logic out_free;
	assign out_free = !ovalid_q || out_ready;

	logic [TW:0] live_cnt;
	always_comb begin
		live_cnt = '0;
		for (int i = 0; i < TARGETS; i++)
			live_cnt = live_cnt + (TW+1)'(valid_q[i]);
	end

	logic is_server;
	assign is_server = (item_q.first_ip == cfg.server_ip) &&
		(item_q.first_port == cfg.server_port);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				case (in_item.mode)
					MODE_TICK:    state_d = ST_COUNT;
					MODE_ADD:     state_d = ST_ADD;
					MODE_SUCCESS: state_d = ST_PEERSCAN;
					default:      state_d = ST_PKT;
				endcase
			end
			ST_COUNT: if (idx_end) state_d = ST_TICK;
			ST_TICK: if (idx_end) state_d = ST_COMPACT;
				else if (live_ok && due_ok && room_ok && out_free) state_d = ST_PUNCH2;
			ST_PUNCH2: if (out_free) state_d = ST_TICK;
			ST_COMPACT: if (idx_end) state_d = ST_FLUSH;
			ST_ADD: if (out_free) state_d = ST_IDLE;
			ST_PEERSCAN: if (known_q) state_d = ST_IDLE;
				else if (idx_q >= IW'(pcnt_q) || idx_q >= IW'(PEERS))
					state_d = ST_MARK;
			ST_MARK: if (idx_end) state_d = ST_IDLE;
			ST_PKT: if (out_free) begin
				if (is_server || idx_end || ep_hit) state_d = ST_IDLE;
			end
			ST_FLUSH: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// payload stores
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) item_q <= in_item;
			ST_TICK: if (!idx_end && live_ok && due_ok && room_ok && out_free) begin
				left_q[ix] <= left_q[ix] - 8'd1;
				due_q[ix]  <= item_q.now + 32'(cfg.interval);
			end
			ST_COMPACT: if (!idx_end && keep && wx != ix) begin
				node_q[wx] <= node_q[ix]; pip_q[wx] <= pip_q[ix];
				ppt_q[wx] <= ppt_q[ix]; qip_q[wx] <= qip_q[ix];
				qpt_q[wx] <= qpt_q[ix]; left_q[wx] <= left_q[ix];
				due_q[wx] <= due_q[ix];
			end
			ST_ADD: if (out_free && live_cnt < (TW+1)'(TARGETS)) begin
				node_q[live_cnt[TW-1:0]] <= item_q.node_id;
				pip_q[live_cnt[TW-1:0]]  <= item_q.first_ip;
				ppt_q[live_cnt[TW-1:0]]  <= item_q.first_port;
				qip_q[live_cnt[TW-1:0]]  <= item_q.second_ip;
				qpt_q[live_cnt[TW-1:0]]  <= item_q.second_port;
				left_q[live_cnt[TW-1:0]] <= cfg.budget;
				due_q[live_cnt[TW-1:0]]  <= item_q.now;
			end
			ST_PEERSCAN: if (!known_q && (idx_q >= IW'(pcnt_q) ||
				idx_q >= IW'(PEERS)) && pcnt_q < CW'(PEERS))
				peer_q[pcnt_q[PW-1:0]] <= item_q.node_id;
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; succ_q <= '0; pcnt_q <= '0;
			idx_q <= '0; wr_q <= '0; nres_q <= '0; etot_q <= '0; known_q <= 1'b0;
			ovalid_q <= 1'b0; obuf_q <= '0;
		end else begin
			if (out_ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0; wr_q <= '0; nres_q <= '0; etot_q <= '0;
					known_q <= 1'b0;
				end
				ST_COUNT: if (idx_end) begin
					idx_q <= '0;
				end else begin
					if (live_ok && due_ok && cnt_room) etot_q <= etot_q + NW'(2);
					idx_q <= idx_q + 1'b1;
				end
				ST_TICK: if (idx_end) begin
					idx_q <= '0;
				end else if (live_ok && due_ok && room_ok) begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						obuf_q <= '{KIND_PUNCH, node_q[ix], pip_q[ix], ppt_q[ix], 1'b0};
						nres_q <= nres_q + NW'(1);
					end
				end else idx_q <= idx_q + 1'b1;
				ST_PUNCH2: if (out_free) begin
					ovalid_q <= 1'b1;
					obuf_q <= '{KIND_PUNCH, node_q[ix], qip_q[ix], qpt_q[ix], punch_last};
					nres_q <= nres_q + NW'(1);
					idx_q <= idx_q + 1'b1;
				end
				ST_COMPACT: if (!idx_end) begin
					if (keep) begin
						valid_q[wx] <= 1'b1;
						succ_q[wx] <= 1'b0;
						wr_q <= wr_q + 1'b1;
					end
					if (ix >= wx && !(keep && wx == ix)) valid_q[ix] <= 1'b0;
					idx_q <= idx_q + 1'b1;
				end
				ST_ADD: if (out_free) begin
					if (live_cnt < (TW+1)'(TARGETS)) begin
						valid_q[live_cnt[TW-1:0]] <= 1'b1;
						succ_q[live_cnt[TW-1:0]] <= 1'b0;
					end else begin
						ovalid_q <= 1'b1;
						obuf_q <= '{KIND_REJECT, item_q.node_id, 32'd0, 16'd0, 1'b1};
					end
				end
				ST_PEERSCAN: if (!known_q) begin
					if (idx_q >= IW'(pcnt_q) || idx_q >= IW'(PEERS)) begin
						if (pcnt_q < CW'(PEERS)) pcnt_q <= pcnt_q + 1'b1;
						idx_q <= '0;
					end else begin
						if (peer_q[idx_q[PW-1:0]] == item_q.node_id) known_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_MARK: if (!idx_end) begin
					if (valid_q[ix] && node_q[ix] == item_q.node_id) succ_q[ix] <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				ST_PKT: if (out_free) begin
					if (is_server) begin
						ovalid_q <= 1'b1;
						obuf_q <= '{KIND_SERVER, 64'd0, item_q.first_ip,
							item_q.first_port, 1'b1};
					end else if (!idx_end) begin
						if (ep_hit) begin
							ovalid_q <= 1'b1;
							obuf_q <= '{KIND_PEER, node_q[ix], item_q.first_ip,
								item_q.first_port, 1'b1};
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FLUSH: ;
				default: ;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign out_item = obuf_q;

	`ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != ST_IDLE, !in_ready)
	`ASSERT_IMP(a_res_cap, clk, arst_n, 1'b1, nres_q <= NW'(MAX_RESULTS))
	`ASSERT_NEXT(a_hold_stall, clk, arst_n, ovalid_q && !out_ready,
		ovalid_q && $stable(obuf_q))
	`ASSERT_IMP(a_pcnt, clk, arst_n, 1'b1, pcnt_q <= CW'(PEERS))

endmodule
